FILE: sv/rpt_pkg.sv
// ----------------------------------------------------------------------------
// rpt_pkg
// Shared types, request codes and constants for the retransmit pending table.
// ----------------------------------------------------------------------------
package rpt_pkg;

    // Default geometry for the top level parameters
    localparam int TABLE_ENTRIES_DEF = 128;
    localparam int SCAN_ENTRIES_DEF  = 16;

    // Most due entries reported by one scan
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [31:0] TIMEOUT_RESET  = 32'd1000;
    localparam logic [7:0]  STATUS_WAITING = 8'd1;

    typedef logic [2:0] req_code_t;

    localparam req_code_t REQ_STORE   = 3'd0;
    localparam req_code_t REQ_ADVANCE = 3'd1;
    localparam req_code_t REQ_RESEND  = 3'd2;
    localparam req_code_t REQ_DELETE  = 3'd3;
    localparam req_code_t REQ_SCAN    = 3'd4;
    localparam req_code_t REQ_READ    = 3'd5;

    // One table entry as held in the memory
    typedef struct packed {
        logic [6:0]  id;
        logic [7:0]  hdr_chk;
        logic [7:0]  body;
        logic [7:0]  body_chk;
        logic [7:0]  status;
        logic [7:0]  retries;
        logic [31:0] stamp;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_SCAN_END
    } rpt_state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic update;
        logic scan_read;
        logic scan_eval;
        logic scan_finish;
    } rpt_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_is_scan;
        logic out_free;
        logic entry_due;
        logic pend_valid;
        logic scan_last_step;
    } rpt_status_t;

endpackage

FILE: sv/retransmit_pending_table_core.sv
// A table request is captured at the accepting edge; its result word is loaded in the update state.
// A table request is a memory read, then a write back; no new request is taken until idle.
// A scan reads, then evaluates, each scanned entry in turn through the single read port.
// Reset: per-entry written flags clear at once, so the whole table reads as zero
// right after reset with no clearing pass; the timeout register resets to 1000.
// ----------------------------------------------------------------------------
// retransmit_pending_table_core
// Table of sent messages awaiting acknowledgement: store, advance, resend,
// delete, read and scan for entries due for retransmission.
// ----------------------------------------------------------------------------
module retransmit_pending_table_core
    import rpt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int SCAN_ENTRIES  = SCAN_ENTRIES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // timeout register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] timeout_wdata,
    // request words
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [2:0]  req_type,
    input  logic [6:0]  entry_id,
    input  logic [7:0]  header_byte,
    input  logic [7:0]  header_check,
    input  logic [7:0]  body_byte,
    input  logic [7:0]  body_check,
    input  logic [7:0]  status_in,
    input  logic [31:0] time_now,
    // result words
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic        found_valid,
    output logic [6:0]  id_out,
    output logic [7:0]  header_out,
    output logic [7:0]  header_check_out,
    output logic [7:0]  body_out,
    output logic [7:0]  body_check_out,
    output logic [7:0]  status_out,
    output logic [7:0]  retries_out,
    output logic        last
);

    rpt_cmd_t    cmd;
    rpt_status_t st;

    // The timeout register takes a write in any cycle; write it only when idle, the block does not enforce this.
    assign cfg_ready = 1'b1;

    // Controller: accept a word in idle, then walk the update or scan sequence.
    rpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .st        (st),
        .cmd       (cmd)
    );

    // Datapath: entry memory, scan walker, one-deep pending slot for a
    // due entry, and the result register that parts the two sides.
    rpt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .SCAN_ENTRIES  (SCAN_ENTRIES)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .st               (st),
        .cfg_we           (cfg_valid && cfg_ready),
        .cfg_data         (timeout_wdata),
        .req_type         (req_type),
        .entry_id         (entry_id),
        .header_byte      (header_byte),
        .header_check     (header_check),
        .body_byte        (body_byte),
        .body_check       (body_check),
        .status_in        (status_in),
        .time_now         (time_now),
        .rsp_valid        (rsp_valid),
        .rsp_stall        (rsp_stall),
        .found_valid      (found_valid),
        .id_out           (id_out),
        .header_out       (header_out),
        .header_check_out (header_check_out),
        .body_out         (body_out),
        .body_check_out   (body_check_out),
        .status_out       (status_out),
        .retries_out      (retries_out),
        .last             (last)
    );

    // A word that carries no entry always closes its request.
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !found_valid) |-> last)
        else $error("empty result word without last");

    // A word that carries an entry shows the rebuilt header.
    a_header_rebuilt: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && found_valid) |-> (header_out == {id_out, 1'b1}))
        else $error("header does not match id");

    // The result register is loaded only when it is free.
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update || cmd.scan_finish) |-> st.out_free)
        else $error("result register overwritten");

    // After an accepted request the block holds off the next one.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request accepted on consecutive cycles");

endmodule

FILE: sv/rpt_datapath.sv
// ----------------------------------------------------------------------------
// rpt_datapath
// Entry memory, request registers, scan walker and result register.
// ----------------------------------------------------------------------------
module rpt_datapath
    import rpt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int SCAN_ENTRIES  = SCAN_ENTRIES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  rpt_cmd_t    cmd,
    output rpt_status_t st,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data,
    input  logic [2:0]  req_type,
    input  logic [6:0]  entry_id,
    input  logic [7:0]  header_byte,
    input  logic [7:0]  header_check,
    input  logic [7:0]  body_byte,
    input  logic [7:0]  body_check,
    input  logic [7:0]  status_in,
    input  logic [31:0] time_now,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic        found_valid,
    output logic [6:0]  id_out,
    output logic [7:0]  header_out,
    output logic [7:0]  header_check_out,
    output logic [7:0]  body_out,
    output logic [7:0]  body_check_out,
    output logic [7:0]  status_out,
    output logic [7:0]  retries_out,
    output logic        last
);

    localparam int AW         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int SCAN_LIMIT = (SCAN_ENTRIES < TABLE_ENTRIES) ? SCAN_ENTRIES : TABLE_ENTRIES;
    localparam int PW         = (SCAN_LIMIT > 1) ? $clog2(SCAN_LIMIT) : 1;
    localparam logic [PW-1:0]    SCAN_LAST = PW'(SCAN_LIMIT - 1);
    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(MAX_RESULTS - 1);

    // Request registers
    req_code_t   req_type_reg;
    logic [6:0]  idx_reg;
    logic        in_range_reg;
    logic [7:0]  hdr_chk_reg;
    logic [7:0]  body_reg;
    logic [7:0]  body_chk_reg;
    logic [7:0]  status_in_reg;
    logic [31:0] time_reg;
    logic [31:0] timeout_reg;

    // Entry memory with per-entry written flags
    entry_t                   mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] written_reg;
    entry_t                   rd_word_reg;
    logic                     rd_hit_reg;

    // Scan walker
    logic [PW-1:0]    scan_ptr_reg;
    logic [CNT_W-1:0] due_cnt_reg;
    entry_t           pend_reg;
    logic             pend_valid_reg;

    // Result register
    logic        rsp_valid_reg;
    logic        found_valid_reg;
    logic [6:0]  id_out_reg;
    logic [7:0]  header_out_reg;
    logic [7:0]  header_check_out_reg;
    logic [7:0]  body_out_reg;
    logic [7:0]  body_check_out_reg;
    logic [7:0]  status_out_reg;
    logic [7:0]  retries_out_reg;
    logic        last_reg;

    logic [6:0]    in_idx;
    logic          in_range;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    entry_t        cur;
    entry_t        new_word;
    logic          mem_we;
    logic          req_ok;
    logic          entry_due;
    logic          out_free;
    logic          load_out;
    entry_t        out_src;
    logic          out_found;
    logic          out_last;

    assign in_idx   = (req_type == REQ_STORE) ? header_byte[7:1] : entry_id;
    assign in_range = ({1'b0, in_idx} < 8'(TABLE_ENTRIES));

    assign rd_en   = (cmd.accept && in_range) || cmd.scan_read;
    assign rd_addr = cmd.accept ? in_idx[AW-1:0] : AW'(scan_ptr_reg);
    assign wr_addr = idx_reg[AW-1:0];

    // Never-written entries read as the cleared value
    assign cur = rd_hit_reg ? rd_word_reg : '0;

    always_comb
    begin
        new_word = cur;
        mem_we   = 1'b0;
        req_ok   = 1'b1;
        case (req_type_reg)
            REQ_STORE:
            begin
                new_word.id       = idx_reg;
                new_word.hdr_chk  = hdr_chk_reg;
                new_word.body     = body_reg;
                new_word.body_chk = body_chk_reg;
                new_word.status   = status_in_reg;
                new_word.retries  = 8'd0;
                new_word.stamp    = time_reg;
                mem_we            = 1'b1;
            end
            REQ_ADVANCE:
            begin
                new_word.retries = 8'd0;
                new_word.status  = cur.status + 8'd1;
                new_word.stamp   = time_reg;
                mem_we           = 1'b1;
            end
            REQ_RESEND:
            begin
                new_word.retries = cur.retries + 8'd1;
                new_word.stamp   = time_reg;
                mem_we           = 1'b1;
            end
            REQ_DELETE:
            begin
                new_word.hdr_chk  = 8'd0;
                new_word.body     = 8'd0;
                new_word.body_chk = 8'd0;
                new_word.retries  = 8'd0;
                new_word.status   = 8'd0;
                new_word.stamp    = 32'd0;
                mem_we            = 1'b1;
            end
            REQ_READ:
            begin
                mem_we = 1'b0;
            end
            default:
            begin
                req_ok = 1'b0;
            end
        endcase
    end

    assign entry_due = (cur.status == STATUS_WAITING) && ((time_reg - cur.stamp) > timeout_reg);
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        st.in_is_scan     = (req_type == REQ_SCAN);
        st.out_free       = out_free;
        st.entry_due      = entry_due;
        st.pend_valid     = pend_valid_reg;
        st.scan_last_step = (scan_ptr_reg == SCAN_LAST) ||
                            (entry_due && (due_cnt_reg == CNT_LAST));
    end

    // Select the word to show
    always_comb
    begin
        load_out  = 1'b0;
        out_src   = pend_reg;
        out_found = 1'b1;
        out_last  = 1'b1;
        if (cmd.update)
        begin
            load_out  = 1'b1;
            out_src   = new_word;
            out_found = in_range_reg && req_ok;
        end
        else if (cmd.scan_eval && entry_due && pend_valid_reg)
        begin
            load_out = 1'b1;
            out_last = 1'b0;
        end
        else if (cmd.scan_finish)
        begin
            load_out  = 1'b1;
            out_found = pend_valid_reg;
        end
    end

    // Memory: write and registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
        if (cmd.update && mem_we && in_range_reg)
        begin
            mem[wr_addr] <= new_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rd_hit_reg  <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_hit_reg <= written_reg[rd_addr];
            end
            if (cmd.update && mem_we && in_range_reg)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // Request capture
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_type_reg  <= req_type;
            idx_reg       <= in_idx;
            in_range_reg  <= in_range;
            hdr_chk_reg   <= header_check;
            body_reg      <= body_byte;
            body_chk_reg  <= body_check;
            status_in_reg <= status_in;
            time_reg      <= time_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            timeout_reg <= cfg_data;
        end
    end

    // Scan walker
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_ptr_reg   <= '0;
            due_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
        end
        else if (cmd.accept)
        begin
            scan_ptr_reg   <= '0;
            due_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
        end
        else if (cmd.scan_eval)
        begin
            scan_ptr_reg <= scan_ptr_reg + PW'(1);
            if (entry_due)
            begin
                due_cnt_reg    <= due_cnt_reg + CNT_W'(1);
                pend_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_eval && entry_due)
        begin
            pend_reg <= cur;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            found_valid_reg      <= out_found;
            id_out_reg           <= out_found ? out_src.id : 7'd0;
            header_out_reg       <= out_found ? {out_src.id, 1'b1} : 8'd0;
            header_check_out_reg <= out_found ? out_src.hdr_chk : 8'd0;
            body_out_reg         <= out_found ? out_src.body : 8'd0;
            body_check_out_reg   <= out_found ? out_src.body_chk : 8'd0;
            status_out_reg       <= out_found ? out_src.status : 8'd0;
            retries_out_reg      <= out_found ? out_src.retries : 8'd0;
            last_reg             <= out_last;
        end
    end

    assign rsp_valid        = rsp_valid_reg;
    assign found_valid      = found_valid_reg;
    assign id_out           = id_out_reg;
    assign header_out       = header_out_reg;
    assign header_check_out = header_check_out_reg;
    assign body_out         = body_out_reg;
    assign body_check_out   = body_check_out_reg;
    assign status_out       = status_out_reg;
    assign retries_out      = retries_out_reg;
    assign last             = last_reg;

endmodule

FILE: sv/rpt_ctrl.sv
// ----------------------------------------------------------------------------
// rpt_ctrl
// Sequencer for table updates and scans.
// ----------------------------------------------------------------------------
module rpt_ctrl
    import rpt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  rpt_status_t st,
    output rpt_cmd_t    cmd
);

    rpt_state_t state_reg;
    rpt_state_t state_next;
    logic       eval_go;

    // Hold a due entry while both the pending slot and the result register are full
    assign eval_go = !(st.entry_due && st.pend_valid && !st.out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = st.in_is_scan ? ST_SCAN_RD : ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (st.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_EV;
            end
            ST_SCAN_EV:
            begin
                if (eval_go)
                begin
                    state_next = st.scan_last_step ? ST_SCAN_END : ST_SCAN_RD;
                end
            end
            ST_SCAN_END:
            begin
                if (st.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall  = 1'b0;
                cmd.accept = req_valid;
            end
            ST_UPDATE:
            begin
                cmd.update = st.out_free;
            end
            ST_SCAN_RD:
            begin
                cmd.scan_read = 1'b1;
            end
            ST_SCAN_EV:
            begin
                cmd.scan_eval = eval_go;
            end
            ST_SCAN_END:
            begin
                cmd.scan_finish = st.out_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

endmodule
